FILE: hw/rtl/road_impulse_noise_detector_defines.svh
// Assertion macros for the ROAD impulse noise detector.
// Included by the top level; no other dependencies.
`ifndef ROAD_IMPULSE_NOISE_DETECTOR_DEFINES_SVH
`define ROAD_IMPULSE_NOISE_DETECTOR_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset
`define RIND_ASSERT_SAME(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked outside reset
`define RIND_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
    else $error(msg);
`else
`define RIND_ASSERT_SAME(lbl, ant, cons, msg)
`define RIND_ASSERT_NEXT(lbl, ant, cons, msg)
`endif

`endif

FILE: hw/rtl/rind_pkg.sv
// Shared types and constants for the ROAD impulse noise detector.
// No dependencies; used by every module of the block.
`default_nettype none

package rind_pkg;

  // Frame geometry limits
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);

  // Field widths
  localparam int SIZE_W  = 13;
  localparam int THR_W   = 10;
  localparam int SUM_W   = 10;
  localparam int COUNT_W = 24;

  // Configuration port
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int REG_SEL_W  = 2;
  localparam logic [REG_SEL_W-1:0] REG_FRAME_WIDTH     = 2'd0;
  localparam logic [REG_SEL_W-1:0] REG_FRAME_HEIGHT    = 2'd1;
  localparam logic [REG_SEL_W-1:0] REG_NOISE_THRESHOLD = 2'd2;

  // Register reset values and clamps
  localparam logic [SIZE_W-1:0] WIDTH_RESET     = 13'd640;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET    = 13'd480;
  localparam logic [THR_W-1:0]  THRESHOLD_RESET = 10'd70;
  localparam logic [SIZE_W-1:0] SIZE_MIN        = 13'd3;
  localparam logic [SIZE_W-1:0] WIDTH_LIMIT     = SIZE_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0] HEIGHT_LIMIT    = SIZE_W'(MAX_HEIGHT);

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef logic [7:0] pix_t;
  typedef pix_t [8:0] window_t;
  typedef pix_t [3:0] quad_t;

  // One line-store entry: pixel two rows up and one row up
  typedef struct packed {
    pix_t top;
    pix_t mid;
  } line_word_t;

  // Per-item control carried alongside the datapath
  typedef struct packed {
    logic decide;
    logic done;
    logic sof;
  } item_tag_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rind_line_buf.sv
// Two-line pixel store: one synchronous RAM word per column, holding both rows.
// Clears itself after reset and forwards a same-edge write to the read port.
// Depends on rind_pkg.
`default_nettype none

module rind_line_buf (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        rd_en,
  input  wire logic [rind_pkg::ADDR_W-1:0] rd_addr,
  output rind_pkg::line_word_t             rd_data,
  input  wire logic                        wr_en,
  input  wire logic [rind_pkg::ADDR_W-1:0] wr_addr,
  input  wire rind_pkg::line_word_t        wr_data,
  output logic                             busy
);

  rind_pkg::line_word_t mem [rind_pkg::MAX_WIDTH];
  rind_pkg::line_word_t mem_q;
  rind_pkg::line_word_t fwd_data;
  logic                 fwd_hit;
  logic [rind_pkg::ADDR_W-1:0] clr_addr;

  // Clearing pass after reset, one entry a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == rind_pkg::ADDR_W'(rind_pkg::MAX_WIDTH - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Write port
  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered and held between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // Same-entry write at the read edge: take the new data instead
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (rd_en) begin
      fwd_hit <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_data <= wr_data;
    end
  end

  assign rd_data = fwd_hit ? fwd_data : mem_q;

endmodule

`default_nettype wire

FILE: hw/rtl/rind_road_calc.sv
// ROAD statistic pipeline: absolute differences, two 4-sorters, merge and sum.
// Three register stages, all advancing on en. Depends on rind_pkg.
`default_nettype none

module rind_road_calc (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire rind_pkg::window_t          window,
  output logic [rind_pkg::SUM_W-1:0]      road_sum
);

  rind_pkg::quad_t diff_lo;
  rind_pkg::quad_t diff_hi;
  rind_pkg::quad_t sort_lo;
  rind_pkg::quad_t sort_hi;
  rind_pkg::quad_t least;
  logic [rind_pkg::SUM_W-1:0] sum_next;

  function automatic rind_pkg::pix_t absdiff(input rind_pkg::pix_t a, input rind_pkg::pix_t b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Four-input sorting network, ascending: three comparator layers
  function automatic rind_pkg::quad_t sort4(input rind_pkg::quad_t v);
    rind_pkg::quad_t s;
    rind_pkg::pix_t  t;
    s = v;
    if (s[0] > s[1]) begin t = s[0]; s[0] = s[1]; s[1] = t; end
    if (s[2] > s[3]) begin t = s[2]; s[2] = s[3]; s[3] = t; end
    if (s[0] > s[2]) begin t = s[0]; s[0] = s[2]; s[2] = t; end
    if (s[1] > s[3]) begin t = s[1]; s[1] = s[3]; s[3] = t; end
    if (s[1] > s[2]) begin t = s[1]; s[1] = s[2]; s[2] = t; end
    return s;
  endfunction

  // Stage A: eight neighbour differences to the centre
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        diff_lo[i] <= absdiff(window[i], window[4]);
        diff_hi[i] <= absdiff(window[i + 5], window[4]);
      end
    end
  end

  // Stage B: sort each half
  always_ff @(posedge clk) begin
    if (en) begin
      sort_lo <= sort4(diff_lo);
      sort_hi <= sort4(diff_hi);
    end
  end

  // Stage C: half-cleaner picks the four smallest, then add them
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      least[i] = (sort_lo[i] < sort_hi[3 - i]) ? sort_lo[i] : sort_hi[3 - i];
    end
    sum_next = rind_pkg::SUM_W'(least[0]) + rind_pkg::SUM_W'(least[1])
             + rind_pkg::SUM_W'(least[2]) + rind_pkg::SUM_W'(least[3]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      road_sum <= sum_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/road_impulse_noise_detector.sv
// Top level of the ROAD impulse noise detector: config registers, raster position,
// 3x3 window, result register and frame count. Depends on rind_pkg, rind_line_buf,
// rind_road_calc and road_impulse_noise_detector_defines.svh.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------------------
//  pixel    | pixel_valid / pixel_stall | pixel_value, start_of_frame
//  result   | result_valid/result_stall | decision_valid, is_noisy, road_sum,
//           |                           | noisy_count, frame_done
//  config   | APB psel/penable/pready   | paddr, pwdata, prdata
//
// One pixel per clock while not stalled; results pass s1-s5, then the result register.
// The pipeline moves as one: a stalled result register stalls the pixel side.
// After reset the line RAM is cleared, one column a cycle, with pixel_stall high;
// configuration writes are taken throughout.
// Reset: rst, synchronous, active high.
`default_nettype none
`include "road_impulse_noise_detector_defines.svh"

module road_impulse_noise_detector (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // pixel channel
  input  wire logic                              pixel_valid,
  output logic                                   pixel_stall,
  input  wire logic [7:0]                        pixel_value,
  input  wire logic                              start_of_frame,
  // result channel
  output logic                                   result_valid,
  input  wire logic                              result_stall,
  output logic                                   decision_valid,
  output logic                                   is_noisy,
  output logic [rind_pkg::SUM_W-1:0]             road_sum,
  output logic [rind_pkg::COUNT_W-1:0]           noisy_count,
  output logic                                   frame_done,
  // configuration port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [rind_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [rind_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [rind_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                   pready
);

  // Configuration
  logic [rind_pkg::SIZE_W-1:0] frame_width;
  logic [rind_pkg::SIZE_W-1:0] frame_height;
  logic [rind_pkg::THR_W-1:0]  noise_threshold;
  logic                        cfg_write;

  // Position and control
  logic                        advance;
  logic                        accept;
  logic                        line_busy;
  logic [rind_pkg::ADDR_W-1:0] column_pos;
  logic [rind_pkg::ROW_W-1:0]  row_pos;
  logic [rind_pkg::ADDR_W-1:0] col_cur;
  logic [rind_pkg::ROW_W-1:0]  row_cur;
  logic [rind_pkg::ADDR_W-1:0] column_pos_next;
  logic [rind_pkg::ROW_W-1:0]  row_pos_next;
  logic [rind_pkg::SIZE_W-1:0] width_use;
  logic [rind_pkg::SIZE_W-1:0] height_use;
  logic                        last_col;
  rind_pkg::item_tag_t         tag_cur;

  // Pipeline stages
  logic                        s1_valid, s2_valid, s3_valid, s4_valid, s5_valid;
  rind_pkg::item_tag_t         s1_tag, s2_tag, s3_tag, s4_tag, s5_tag;
  rind_pkg::pix_t              s1_pix;
  logic [rind_pkg::ADDR_W-1:0] s1_addr;
  rind_pkg::line_word_t        line_q;
  rind_pkg::line_word_t        line_wr;
  logic                        line_wr_en;
  rind_pkg::window_t           window_regs;
  logic [rind_pkg::SUM_W-1:0]  calc_sum;

  // Frame count
  logic [rind_pkg::COUNT_W-1:0] flag_total;
  logic [rind_pkg::COUNT_W-1:0] count_base;
  logic [rind_pkg::COUNT_W-1:0] count_next;
  logic                         noisy_next;

  // APB registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width     <= rind_pkg::WIDTH_RESET;
      frame_height    <= rind_pkg::HEIGHT_RESET;
      noise_threshold <= rind_pkg::THRESHOLD_RESET;
    end else if (cfg_write) begin
      case (paddr[3:2])
        rind_pkg::REG_FRAME_WIDTH:     frame_width     <= pwdata[rind_pkg::SIZE_W-1:0];
        rind_pkg::REG_FRAME_HEIGHT:    frame_height    <= pwdata[rind_pkg::SIZE_W-1:0];
        rind_pkg::REG_NOISE_THRESHOLD: noise_threshold <= pwdata[rind_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      rind_pkg::REG_FRAME_WIDTH:     prdata = rind_pkg::APB_DATA_W'(frame_width);
      rind_pkg::REG_FRAME_HEIGHT:    prdata = rind_pkg::APB_DATA_W'(frame_height);
      rind_pkg::REG_NOISE_THRESHOLD: prdata = rind_pkg::APB_DATA_W'(noise_threshold);
      default:                       prdata = '0;
    endcase
  end

  // Handshake: whole pipeline shifts unless a result is held
  assign advance     = !result_valid || !result_stall;
  assign pixel_stall = line_busy || !advance;
  assign accept      = pixel_valid && !pixel_stall;

  // Raster position of the incoming item
  always_comb begin
    width_use = frame_width;
    if (frame_width < rind_pkg::SIZE_MIN) width_use = rind_pkg::SIZE_MIN;
    else if (frame_width > rind_pkg::WIDTH_LIMIT) width_use = rind_pkg::WIDTH_LIMIT;
    height_use = frame_height;
    if (frame_height < rind_pkg::SIZE_MIN) height_use = rind_pkg::SIZE_MIN;
    else if (frame_height > rind_pkg::HEIGHT_LIMIT) height_use = rind_pkg::HEIGHT_LIMIT;

    col_cur = start_of_frame ? '0 : column_pos;
    row_cur = start_of_frame ? '0 : row_pos;

    last_col       = (rind_pkg::SIZE_W'(col_cur) + 1'b1) >= width_use;
    tag_cur.sof    = start_of_frame;
    tag_cur.decide = (row_cur >= rind_pkg::ROW_W'(2)) && (col_cur >= rind_pkg::ADDR_W'(2));
    tag_cur.done   = last_col && ((rind_pkg::SIZE_W'(row_cur) + 1'b1) >= height_use);

    if (tag_cur.done) begin
      column_pos_next = '0;
      row_pos_next    = '0;
    end else if (last_col) begin
      column_pos_next = '0;
      row_pos_next    = row_cur + 1'b1;
    end else begin
      column_pos_next = col_cur + 1'b1;
      row_pos_next    = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos <= '0;
      row_pos    <= '0;
    end else if (accept) begin
      column_pos <= column_pos_next;
      row_pos    <= row_pos_next;
    end
  end

  // Line store: read at accept, written back when the item leaves stage s1
  assign line_wr_en  = advance && s1_valid;
  assign line_wr.top = line_q.mid;
  assign line_wr.mid = s1_pix;

  rind_line_buf u_line_buf (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (col_cur),
    .rd_data (line_q),
    .wr_en   (line_wr_en),
    .wr_addr (s1_addr),
    .wr_data (line_wr),
    .busy    (line_busy)
  );

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      s4_valid     <= 1'b0;
      s5_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else if (advance) begin
      s1_valid     <= accept;
      s2_valid     <= s1_valid;
      s3_valid     <= s2_valid;
      s4_valid     <= s3_valid;
      s5_valid     <= s4_valid;
      result_valid <= s5_valid;
    end
  end

  // Stage payloads and tags
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_pix  <= pixel_value;
      s1_addr <= col_cur;
      s1_tag  <= tag_cur;
      s2_tag  <= s1_tag;
      s3_tag  <= s2_tag;
      s4_tag  <= s3_tag;
      s5_tag  <= s4_tag;
    end
  end

  // 3x3 window shifts left by one column per item
  always_ff @(posedge clk) begin
    if (rst) begin
      window_regs <= '0;
    end else if (line_wr_en) begin
      window_regs[0] <= window_regs[1];
      window_regs[1] <= window_regs[2];
      window_regs[2] <= line_q.top;
      window_regs[3] <= window_regs[4];
      window_regs[4] <= window_regs[5];
      window_regs[5] <= line_q.mid;
      window_regs[6] <= window_regs[7];
      window_regs[7] <= window_regs[8];
      window_regs[8] <= s1_pix;
    end
  end

  rind_road_calc u_road_calc (
    .clk      (clk),
    .en       (advance),
    .window   (window_regs),
    .road_sum (calc_sum)
  );

  // Decision and saturating frame count
  always_comb begin
    count_base = s5_tag.sof ? '0 : flag_total;
    noisy_next = s5_tag.decide && (calc_sum > noise_threshold);
    count_next = count_base;
    if (noisy_next && (count_base != rind_pkg::COUNT_MAX)) begin
      count_next = count_base + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flag_total <= '0;
    end else if (advance && s5_valid) begin
      flag_total <= s5_tag.done ? '0 : count_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (advance) begin
      decision_valid <= s5_tag.decide;
      is_noisy       <= noisy_next;
      road_sum       <= s5_tag.decide ? calc_sum : '0;
      noisy_count    <= count_next;
      frame_done     <= s5_tag.done;
    end
  end

  // Checks
  `RIND_ASSERT_SAME(a_no_take_while_clearing, line_busy, pixel_stall, "item taken during line clear")
  `RIND_ASSERT_SAME(a_border_zero, result_valid && !decision_valid, (road_sum == '0) && !is_noisy, "border result not zero")
  `RIND_ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid && $stable(noisy_count) && $stable(road_sum), "held result changed")
  `RIND_ASSERT_NEXT(a_window_on_write, !line_wr_en, $stable(window_regs), "window moved without an item")

endmodule

`default_nettype wire
